[design/assert_macros.svh]
// Assertion macros shared by the booth multiplier RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/brm_pkg.sv]
// Package for the radix-2 Booth multiplier: Booth operation codes, the cell
// control struct and the product width. No dependencies.
package brm_pkg;

    localparam int PRODUCT_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_NONE = 2'b00,
        OP_ADD  = 2'b01,
        OP_SUB  = 2'b10
    } booth_op_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic      clear;
        logic      step;
        booth_op_t op;
    } cell_ctrl_t;

    // Booth pair (current low multiplier bit, previous bit) to operation.
    function automatic booth_op_t booth_decode(input logic q0, input logic qprev);
        booth_op_t op;
        unique case ({q0, qprev})
            2'b01:   op = OP_ADD;
            2'b10:   op = OP_SUB;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

[design/brm_in_if.sv]
// Input channel of the Booth multiplier: valid/ready plus both operands.
// Depends on nothing; the operand width is an interface parameter.
interface brm_in_if #(
    parameter int W = 16
) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] multiplicand;
    logic signed [W-1:0] multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

[design/brm_out_if.sv]
// Output channel of the Booth multiplier: valid/ready plus the product.
// Depends on brm_pkg for the product width.
interface brm_out_if ();
    import brm_pkg::*;

    logic                            valid;
    logic                            ready;
    logic signed [PRODUCT_WIDTH-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

[design/brm_cell.sv]
// One bit slice of the Booth accumulator: a full-adder stage and one
// accumulator bit that takes its shift input (its left neighbor's sum in the chain) on every step.
// Depends on brm_pkg for the cell control struct.
module brm_cell (
    input  logic                clk,
    input  brm_pkg::cell_ctrl_t ctrl,
    input  logic                m_bit,
    input  logic                carry_in,
    input  logic                shift_in,
    output logic                carry_out,
    output logic                sum_bit,
    output logic                acc_bit
);
    import brm_pkg::*;

    logic acc_reg;
    logic acc_next;
    logic addend;

    always_comb
    begin
        unique case (ctrl.op)
            OP_ADD:  addend = m_bit;
            OP_SUB:  addend = ~m_bit;
            default: addend = 1'b0;
        endcase
    end

    assign sum_bit   = acc_reg ^ addend ^ carry_in;
    assign carry_out = (acc_reg & addend) | (acc_reg & carry_in) | (addend & carry_in);

    always_comb
    begin
        priority if (ctrl.clear)
            acc_next = 1'b0;
        else if (ctrl.step)
            acc_next = shift_in;
        else
            acc_next = acc_reg;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc_bit = acc_reg;
endmodule

[design/booth_radix2_multiplier.sv]
// Radix-2 Booth signed multiplier, one accumulator cell per bit of A.
// Each transaction is loaded, then takes one add-and-shift step per multiplier bit
// through the cell chain in RUN, then waits in FINISH until the output register
// is free; the next transaction can be taken while the product moves there.
// Reset (rst_n, asynchronous, active low) empties the sequencer and output
// register; datapath registers are loaded with each new transaction.
module booth_radix2_multiplier #(
    parameter int OPERAND_WIDTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    brm_in_if.sink     in_ch,
    brm_out_if.source  out_ch
);
    import brm_pkg::*;

    `include "assert_macros.svh"

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = (W > 1) ? $clog2(W) : 1;
    localparam int PW = PRODUCT_WIDTH;

    // One-hot sequencer. RUN performs one Booth step per cycle; FINISH hands
    // the product to the output register as soon as that register is free.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_RUN    = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [W-1:0]    m_reg, m_next;
    logic [W-1:0]    q_reg, q_next;
    logic            qprev_reg, qprev_next;
    logic            out_valid_reg, out_valid_next;
    logic [PW-1:0]   product_reg, product_next;

    logic            in_take;
    logic            out_free;
    logic            last_step;
    cell_ctrl_t      ctrl;

    // Chain wiring: carries ripple leftward, sums shift one place rightward.
    logic [W+1:0]    carry_w;
    logic [W:0]      sum_w;
    logic [W:0]      acc_w;

    logic [2*W-1:0]  full_product;
    logic [PW+2*W-1:0] wide_product;

    // The output register can accept a new product when it is empty or when
    // the current one is being taken in this cycle.
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign last_step = (count_reg == CW'(W - 1));

    // A new transaction is taken when idle, or while the finished product
    // moves into the output register, so back-to-back items do not pass through IDLE.
    assign in_ch.ready = (state_reg == ST_IDLE) || ((state_reg == ST_FINISH) && out_free);
    assign in_take     = in_ch.valid && in_ch.ready;

    assign ctrl.clear = in_take;
    assign ctrl.step  = (state_reg == ST_RUN);
    assign ctrl.op    = (state_reg == ST_RUN) ? booth_decode(q_reg[0], qprev_reg) : OP_NONE;

    // Subtraction is addition of the inverted multiplicand plus one.
    assign carry_w[0] = (ctrl.op == OP_SUB);

    genvar gi;
    generate
        for (gi = 0; gi <= W; gi++)
        begin : g_cell
            logic m_bit;
            logic shift_in;

            if (gi < W)
            begin : g_body
                assign m_bit    = m_reg[gi];
                assign shift_in = sum_w[gi+1];
            end
            else
            begin : g_guard
                // Guard cell: sign extension of the multiplicand, and the
                // arithmetic shift keeps its own bit.
                assign m_bit    = m_reg[W-1];
                assign shift_in = sum_w[gi];
            end

            brm_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .m_bit     (m_bit),
                .carry_in  (carry_w[gi]),
                .shift_in  (shift_in),
                .carry_out (carry_w[gi+1]),
                .sum_bit   (sum_w[gi]),
                .acc_bit   (acc_w[gi])
            );
        end
    endgenerate

    // The product is A:Q with the guard bit dropped, then fitted to the
    // product field: low bits kept, zero filled above a narrow product.
    assign full_product = {acc_w[W-1:0], q_reg};
    assign wide_product = {{PW{1'b0}}, full_product};

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_next         = m_reg;
        q_next         = q_reg;
        qprev_next     = qprev_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        product_next   = product_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                // The low sum bit falls into the top of Q on every step.
                q_next     = {sum_w[0], q_reg[W-1:1]};
                qprev_next = q_reg[0];
                count_next = count_reg + CW'(1);
                if (last_step)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    product_next   = wide_product[PW-1:0];
                    out_valid_next = 1'b1;
                    state_next     = in_take ? ST_RUN : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_take)
        begin
            m_next     = in_ch.multiplicand;
            q_next     = in_ch.multiplier;
            qprev_next = 1'b0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg       <= m_next;
        q_reg       <= q_next;
        qprev_reg   <= qprev_next;
        product_reg <= product_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.product = product_reg;

    // A taken transaction always starts its step sequence at step zero.
    `ASSERT_NEXT(a_load_starts_run, clk, rst_n, in_take, (state_reg == ST_RUN) && (count_reg == '0))
    // The last Booth step always hands over to the finishing state.
    `ASSERT_NEXT(a_last_step_finishes, clk, rst_n, (state_reg == ST_RUN) && last_step, state_reg == ST_FINISH)
    // Finishing with a free output register always presents a result.
    `ASSERT_NEXT(a_finish_emits, clk, rst_n, (state_reg == ST_FINISH) && out_free, out_valid_reg)
endmodule
